[src/bsr_pkg.sv]
package bsr_pkg;

    // Field widths of the request and result channels.
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 13;
    localparam int DATA_W     = 14;
    localparam int DOF_W      = 13;
    localparam int IDX_W      = 19;
    localparam int STAT_W     = 2;
    localparam int COLV_W     = 10;

    // Configuration register widths.
    localparam int BS_W       = 4;
    localparam int NROW_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Largest block edge honoured by the lookup.
    localparam int MAX_BLOCK  = 8;

    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_COL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WR_COUNT = 2'd3;

    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT      = 2'd3;

    // Write strobes into the three structure tables.
    typedef struct packed {
        logic start_we;
        logic col_we;
        logic count_we;
    } t_tbl_wr;

endpackage

[src/bsr_value_index_lookup.sv]
// Channel   | Signals                                        | Direction
// ----------+------------------------------------------------+----------
// request   | i_in_valid, o_in_stall, i_command .. i_dof_col | in
// result    | o_out_valid, i_out_stall, o_value_index,       | out
//           | o_status                                       |
// config    | i_cfg_we, i_cfg_index, i_cfg_data              | in
//
// One request is worked on at a time; a write passes through S_WRITE and S_OUT to the output register.
// A lookup runs the bit-serial divider, reads the row table (S_RD_START, S_RD_NEXT,
// S_RD_END), scans the row's stored block columns, does the index arithmetic (S_MUL1 to
// S_ADD2) and loads the output register. A row outside the matrix goes from S_DIV to S_OUT.
// Reset is synchronous; the tables are not cleared and hold garbage until written.
// A stalled result waits in the output register while the next request is taken.
module bsr_value_index_lookup #(
    parameter int MAX_BLOCK_ROWS = 1024,
    parameter int MAX_ENTRIES    = 8192
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bsr_pkg::CMD_W-1:0]        i_command,
    input  logic [bsr_pkg::ADDR_W-1:0]       i_table_address,
    input  logic [bsr_pkg::DATA_W-1:0]       i_table_data,
    input  logic [bsr_pkg::DOF_W-1:0]        i_dof_row,
    input  logic [bsr_pkg::DOF_W-1:0]        i_dof_col,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bsr_pkg::IDX_W-1:0]        o_value_index,
    output logic [bsr_pkg::STAT_W-1:0]       o_status,

    input  logic                             i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ROW_AW = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
    localparam int COL_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int P_W    = (ENT_W > bsr_pkg::DATA_W) ? ENT_W : bsr_pkg::DATA_W;
    localparam int NR_W   = $clog2(MAX_BLOCK_ROWS + 1);
    localparam int NRC_W  = (NR_W > bsr_pkg::NROW_W) ? NR_W : bsr_pkg::NROW_W;
    localparam int BW     = bsr_pkg::BS_W;
    localparam int BSQ_W  = 2 * bsr_pkg::BS_W;
    localparam int DW     = bsr_pkg::DOF_W;
    localparam int IW     = bsr_pkg::IDX_W;
    localparam int TW     = bsr_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_DIV,
        S_RD_START,
        S_RD_NEXT,
        S_RD_END,
        S_SCAN,
        S_MUL1,
        S_MUL2,
        S_ADD1,
        S_ADD2,
        S_OUT
    } t_state;

    // Configuration registers.
    logic [BW-1:0]                     r_cfg_bs;
    logic [bsr_pkg::NROW_W-1:0]        r_cfg_rows;
    logic [TW-1:0]                     r_cfg_entries;
    logic                              r_cfg_layout;

    t_state                            r_state;
    logic [bsr_pkg::CMD_W-1:0]         r_cmd;
    logic [bsr_pkg::ADDR_W-1:0]        r_addr;
    logic [TW-1:0]                     r_data;
    logic [BW-1:0]                     r_bs;
    logic [BSQ_W-1:0]                  r_bsq;
    logic [DW-1:0]                     r_brow;
    logic [DW-1:0]                     r_bcol;
    logic [BW-1:0]                     r_r;
    logic [BW-1:0]                     r_c;
    logic [TW-1:0]                     r_start;
    logic [TW-1:0]                     r_cnt;
    logic [P_W-1:0]                    r_end;
    logic [P_W-1:0]                    r_p;
    logic [P_W-1:0]                    r_k;
    logic                              r_pend;
    logic [P_W-1:0]                    r_hit_p;
    logic [P_W-1:0]                    r_hit_k;
    logic [IW-1:0]                     r_base;
    logic [IW-1:0]                     r_kbs;
    logic [BSQ_W-1:0]                  r_rbs;
    logic [IW-1:0]                     r_term;
    logic [IW-1:0]                     r_sum1;
    logic [IW-1:0]                     r_sum2;
    logic [IW-1:0]                     r_res_idx;
    logic [bsr_pkg::STAT_W-1:0]        r_res_st;
    logic                              r_out_valid;
    logic [IW-1:0]                     r_out_idx;
    logic [bsr_pkg::STAT_W-1:0]        r_out_st;

    logic                              in_accept;
    logic [BW-1:0]                     bs_c;
    logic [NRC_W-1:0]                  nrows;
    logic [P_W-1:0]                    nent;
    logic                              last_row;
    logic [P_W-1:0]                    end_raw;
    logic [P_W-1:0]                    end_c;
    logic [P_W-1:0]                    base_sel;
    logic                              col_hit;
    logic                              row_out;

    logic                              div_start;
    logic                              div_done;
    logic [DW-1:0]                     div_row_q;
    logic [BW-1:0]                     div_row_r;
    logic [DW-1:0]                     div_col_q;
    logic [BW-1:0]                     div_col_r;

    bsr_pkg::t_tbl_wr                  tbl_wr;
    logic [ROW_AW-1:0]                 row_raddr;
    logic [COL_AW-1:0]                 col_raddr;
    logic [TW-1:0]                     start_rdata;
    logic [TW-1:0]                     count_rdata;
    logic [bsr_pkg::COLV_W-1:0]        col_rdata;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Out-of-range register values are pulled back into their legal range.
    always_comb begin
        if (r_cfg_bs == '0) begin
            bs_c = BW'(1);
        end else if (32'(r_cfg_bs) > 32'(bsr_pkg::MAX_BLOCK)) begin
            bs_c = BW'(bsr_pkg::MAX_BLOCK);
        end else begin
            bs_c = r_cfg_bs;
        end

        if (r_cfg_rows == '0) begin
            nrows = NRC_W'(1);
        end else if (32'(r_cfg_rows) > 32'(MAX_BLOCK_ROWS)) begin
            nrows = NRC_W'(MAX_BLOCK_ROWS);
        end else begin
            nrows = NRC_W'(r_cfg_rows);
        end

        if (32'(r_cfg_entries) > 32'(MAX_ENTRIES)) begin
            nent = P_W'(MAX_ENTRIES);
        end else begin
            nent = P_W'(r_cfg_entries);
        end
    end

    assign row_out  = (32'(div_row_q) >= 32'(nrows));
    assign last_row = (32'(r_brow) == (32'(nrows) - 32'd1));
    assign end_raw  = last_row ? nent : P_W'(start_rdata);
    assign end_c    = (end_raw > P_W'(MAX_ENTRIES)) ? P_W'(MAX_ENTRIES) : end_raw;
    assign base_sel = r_cfg_layout ? r_hit_p : P_W'(r_start);

    // A block column of 1024 or more can never equal a 10-bit column entry.
    assign col_hit  = (DW'(col_rdata) == r_bcol);

    assign row_raddr = (r_state == S_RD_START) ? ROW_AW'(r_brow) : ROW_AW'(r_brow + DW'(1));
    assign col_raddr = COL_AW'(r_p);

    assign div_start = in_accept && (i_command == bsr_pkg::CMD_LOOKUP);

    always_comb begin
        tbl_wr = '0;
        if (r_state == S_WRITE) begin
            unique case (r_cmd)
                bsr_pkg::CMD_WR_START: tbl_wr.start_we = 1'b1;
                bsr_pkg::CMD_WR_COL:   tbl_wr.col_we   = 1'b1;
                bsr_pkg::CMD_WR_COUNT: tbl_wr.count_we = 1'b1;
                default:               tbl_wr = '0;
            endcase
        end
    end

    bsr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (bs_c),
        .i_row      (i_dof_row),
        .i_col      (i_dof_col),
        .o_done     (div_done),
        .o_row_quot (div_row_q),
        .o_row_rem  (div_row_r),
        .o_col_quot (div_col_q),
        .o_col_rem  (div_col_r)
    );

    bsr_tables #(
        .MAX_BLOCK_ROWS (MAX_BLOCK_ROWS),
        .MAX_ENTRIES    (MAX_ENTRIES)
    ) u_tables (
        .i_clk         (i_clk),
        .i_wr          (tbl_wr),
        .i_wr_addr     (r_addr),
        .i_wr_data     (r_data),
        .i_row_raddr   (row_raddr),
        .i_col_raddr   (col_raddr),
        .o_start_rdata (start_rdata),
        .o_count_rdata (count_rdata),
        .o_col_rdata   (col_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bs      <= BW'(1);
            r_cfg_rows    <= bsr_pkg::NROW_W'(1);
            r_cfg_entries <= '0;
            r_cfg_layout  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsr_pkg::CFG_BLOCK_SIZE:  r_cfg_bs      <= i_cfg_data[BW-1:0];
                bsr_pkg::CFG_BLOCK_ROWS:  r_cfg_rows    <= i_cfg_data[bsr_pkg::NROW_W-1:0];
                bsr_pkg::CFG_ENTRY_COUNT: r_cfg_entries <= i_cfg_data;
                bsr_pkg::CFG_LAYOUT:      r_cfg_layout  <= i_cfg_data[0];
                default:                  r_cfg_layout  <= r_cfg_layout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded instead of being emptied.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd  <= i_command;
                        r_addr <= i_table_address;
                        r_data <= i_table_data;
                        r_bs   <= bs_c;
                        r_bsq  <= BSQ_W'(bs_c) * BSQ_W'(bs_c);
                        r_state <= (i_command == bsr_pkg::CMD_LOOKUP) ? S_DIV : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_res_idx <= '0;
                    r_res_st  <= bsr_pkg::ST_WRITE;
                    r_state   <= S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_brow <= div_row_q;
                        r_bcol <= div_col_q;
                        r_r    <= div_row_r;
                        r_c    <= div_col_r;
                        if (row_out) begin
                            r_res_idx <= '0;
                            r_res_st  <= bsr_pkg::ST_MISS;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_RD_START;
                        end
                    end
                end
                S_RD_START: begin
                    r_state <= S_RD_NEXT;
                end
                S_RD_NEXT: begin
                    r_start <= start_rdata;
                    r_cnt   <= count_rdata;
                    r_state <= S_RD_END;
                end
                S_RD_END: begin
                    r_end   <= end_c;
                    r_p     <= P_W'(r_start);
                    r_k     <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // The entry read last cycle sits one behind the issue pointer.
                    if (r_pend && col_hit) begin
                        r_hit_p <= r_p - P_W'(1);
                        r_hit_k <= r_k - P_W'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_MUL1;
                    end else if (r_p < r_end) begin
                        r_pend <= 1'b1;
                        r_p    <= r_p + P_W'(1);
                        r_k    <= r_k + P_W'(1);
                    end else begin
                        r_pend    <= 1'b0;
                        r_res_idx <= '0;
                        r_res_st  <= bsr_pkg::ST_MISS;
                        r_state   <= S_OUT;
                    end
                end
                S_MUL1: begin
                    r_base  <= IW'(IW'(base_sel) * IW'(r_bsq));
                    r_kbs   <= IW'(IW'(r_hit_k) * IW'(r_bs));
                    r_rbs   <= BSQ_W'(r_r) * BSQ_W'(r_bs);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_term  <= r_cfg_layout ? '0 : IW'(IW'(r_rbs) * IW'(r_cnt));
                    r_state <= S_ADD1;
                end
                S_ADD1: begin
                    r_sum1  <= r_base + r_term;
                    r_sum2  <= (r_cfg_layout ? IW'(r_rbs) : r_kbs) + IW'(r_c);
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    r_res_idx <= r_sum1 + r_sum2;
                    r_res_st  <= bsr_pkg::ST_FOUND;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_res_idx;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_index = r_out_idx;
    assign o_status      = r_out_st;

endmodule

[src/bsr_divider.sv]
module bsr_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bsr_pkg::BS_W-1:0]     i_divisor,
    input  logic [bsr_pkg::DOF_W-1:0]    i_row,
    input  logic [bsr_pkg::DOF_W-1:0]    i_col,
    output logic                         o_done,
    output logic [bsr_pkg::DOF_W-1:0]    o_row_quot,
    output logic [bsr_pkg::BS_W-1:0]     o_row_rem,
    output logic [bsr_pkg::DOF_W-1:0]    o_col_quot,
    output logic [bsr_pkg::BS_W-1:0]     o_col_rem
);

    localparam int DW    = bsr_pkg::DOF_W;
    localparam int BW    = bsr_pkg::BS_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rq;
    logic [DW-1:0]    r_cq;
    logic [BW-1:0]    r_rr;
    logic [BW-1:0]    r_cr;
    logic [BW-1:0]    r_div;

    logic [BW:0]      row_trial;
    logic [BW:0]      col_trial;
    logic             row_ge;
    logic             col_ge;
    logic [BW-1:0]    n_rr;
    logic [BW-1:0]    n_cr;

    // Restoring division, one quotient bit per cycle for row and column together.
    always_comb begin
        row_trial = {r_rr, r_rq[DW-1]};
        col_trial = {r_cr, r_cq[DW-1]};
        row_ge    = (row_trial >= {1'b0, r_div});
        col_ge    = (col_trial >= {1'b0, r_div});
        n_rr      = row_ge ? BW'(row_trial - {1'b0, r_div}) : BW'(row_trial);
        n_cr      = col_ge ? BW'(col_trial - {1'b0, r_div}) : BW'(col_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rq  <= i_row;
            r_cq  <= i_col;
            r_rr  <= '0;
            r_cr  <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rq <= {r_rq[DW-2:0], row_ge};
            r_cq <= {r_cq[DW-2:0], col_ge};
            r_rr <= n_rr;
            r_cr <= n_cr;
        end
    end

    assign o_done     = r_done;
    assign o_row_quot = r_rq;
    assign o_row_rem  = r_rr;
    assign o_col_quot = r_cq;
    assign o_col_rem  = r_cr;

endmodule

[src/bsr_tables.sv]
module bsr_tables #(
    parameter int MAX_BLOCK_ROWS = 1024,
    parameter int MAX_ENTRIES    = 8192,
    localparam int ROW_AW = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1,
    localparam int COL_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  bsr_pkg::t_tbl_wr              i_wr,
    input  logic [bsr_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [bsr_pkg::DATA_W-1:0]    i_wr_data,
    input  logic [ROW_AW-1:0]             i_row_raddr,
    input  logic [COL_AW-1:0]             i_col_raddr,
    output logic [bsr_pkg::DATA_W-1:0]    o_start_rdata,
    output logic [bsr_pkg::DATA_W-1:0]    o_count_rdata,
    output logic [bsr_pkg::COLV_W-1:0]    o_col_rdata
);

    localparam int DW = bsr_pkg::DATA_W;
    localparam int CW = bsr_pkg::COLV_W;

    // Each row entry holds the row start in its low half and the row count in its high half.
    logic [2*DW-1:0] r_row_mem [MAX_BLOCK_ROWS];
    logic [CW-1:0]   r_col_mem [MAX_ENTRIES];

    logic [2*DW-1:0] r_row_rd;
    logic [CW-1:0]   r_col_rd;

    logic            row_ok;
    logic            col_ok;

    // A write beyond a table's depth is dropped.
    assign row_ok = (32'(i_wr_addr) < 32'(MAX_BLOCK_ROWS));
    assign col_ok = (32'(i_wr_addr) < 32'(MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (i_wr.start_we && row_ok) begin
            r_row_mem[ROW_AW'(i_wr_addr)][DW-1:0] <= i_wr_data;
        end
        if (i_wr.count_we && row_ok) begin
            r_row_mem[ROW_AW'(i_wr_addr)][2*DW-1:DW] <= i_wr_data;
        end
        r_row_rd <= r_row_mem[i_row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.col_we && col_ok) begin
            r_col_mem[COL_AW'(i_wr_addr)] <= i_wr_data[CW-1:0];
        end
        r_col_rd <= r_col_mem[i_col_raddr];
    end

    assign o_start_rdata = r_row_rd[DW-1:0];
    assign o_count_rdata = r_row_rd[2*DW-1:DW];
    assign o_col_rdata   = r_col_rd;

endmodule

[src/bsr_checker.sv]
module bsr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [bsr_pkg::IDX_W-1:0]     o_value_index,
    input  logic [bsr_pkg::STAT_W-1:0]    o_status
);

    // Only one request is in flight, so the request side closes after each accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another was in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_value_index) && $stable(o_status)))
        else $error("stalled result changed or was dropped");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == bsr_pkg::ST_FOUND || o_status == bsr_pkg::ST_MISS
                         || o_status == bsr_pkg::ST_WRITE))
        else $error("result carries an unknown status");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != bsr_pkg::ST_FOUND) |-> (o_value_index == '0))
        else $error("miss or write result carries a non-zero index");

endmodule

bind bsr_value_index_lookup bsr_checker u_bsr_checker (.*);
